// File: src/fsbe_pkg.sv
// Package with the shared types and constants of the float stack bytecode executor.
package fsbe_pkg;

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_PUSH = 3'd1,
    OP_NEG  = 3'd2,
    OP_ADD  = 3'd3,
    OP_SUB  = 3'd4,
    OP_MUL  = 3'd5,
    OP_DIV  = 3'd6,
    OP_RET  = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_RETURNED  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_BADINDEX  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_NEG,
    S_RET,
    S_BIN_A,
    S_BIN_B,
    S_BIN_WAIT
  } ctl_state_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CHK,
    F_ADD,
    F_PRE,
    F_MUL,
    F_DIV,
    F_NORM,
    F_ROUND
  } fpu_state_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } fpu_req_t;

  localparam logic [63:0] SignBit    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QuietBit   = 64'h0008_0000_0000_0000;
  localparam logic [63:0] DefaultNan = 64'hFFF8_0000_0000_0000;
  localparam logic signed [13:0] ExpBias = 14'sd1023;

endpackage

// File: src/float_stack_bytecode_executor.sv
// Top level of the float stack bytecode executor: sequencer, operand stack and constant pool.
//
// Channel  Direction  Handshake              Payload
// command  in         start / busy           op_i, pool_index_i, pool_value_i
// result   out        valid_o (one cycle)    status_o, return_value_o, stack_level_o
//
// A command transfer happens at a rising edge with start high and busy low.
// Load and every rejected command finish in that edge; the result is shown
// in the next cycle. Push, negate and return pass through their own state,
// since the stack or pool memory read is registered. Add and subtract pass
// through alignment, normalization and rounding; multiply and divide run the
// radix-2 loop of the shared arithmetic unit before these. Normalizing shifts,
// subnormal operands and tiny results make a command take longer.
// Reset empties the stack and the pool count. The receiver cannot stall, so
// each result is on the ports for exactly one cycle.
module float_stack_bytecode_executor #(
  parameter int STACK_DEPTH = 256,
  parameter int POOL_DEPTH  = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op_i,
  input  logic [9:0]  pool_index_i,
  input  logic [63:0] pool_value_i,
  output logic        valid_o,
  output logic [2:0]  status_o,
  output logic [63:0] return_value_o,
  output logic [8:0]  stack_level_o
);

  // Widths of the stack address, the stack count, the pool address and the
  // count of loaded pool slots.
  localparam int SA  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int PA  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int PCW = $clog2(POOL_DEPTH + 1);

  fsbe_pkg::ctl_state_e state_q, state_d;
  fsbe_pkg::op_e        op_q, op_d;
  fsbe_pkg::op_e        op_in;
  logic [SPW-1:0]       sp_q, sp_d;
  logic [PCW-1:0]       plc_q, plc_d;
  logic [63:0]          rhs_q, rhs_d;

  logic                 res_valid_q, res_valid_d;
  fsbe_pkg::status_e    res_status_q, res_status_d;
  logic [63:0]          res_value_q, res_value_d;
  logic [8:0]           res_level_q, res_level_d;

  // Operand stack memory, one write and one registered read per cycle.
  logic [63:0]   stack_mem [STACK_DEPTH];
  logic          stk_we;
  logic [SA-1:0] stk_waddr, stk_raddr;
  logic [63:0]   stk_wdata, stk_rdata_q;

  // Constant pool memory, addressed straight from the command.
  logic [63:0]   pool_mem [POOL_DEPTH];
  logic          pool_we;
  logic [PA-1:0] pool_addr;
  logic [63:0]   pool_rdata_q;

  fsbe_pkg::fpu_req_t fpu_req;
  logic               fpu_done;
  logic [63:0]        fpu_res;

  logic [SA-1:0] top_addr, second_addr;
  logic          load_ok, push_ok, stack_full;
  logic [31:0]   idx_plus1;

  assign op_in       = fsbe_pkg::op_e'(op_i);
  assign top_addr    = SA'(sp_q - SPW'(1));
  assign second_addr = SA'(sp_q - SPW'(2));
  assign pool_addr   = PA'(pool_index_i);
  assign idx_plus1   = 32'(pool_index_i) + 32'd1;
  assign load_ok     = 32'(pool_index_i) < 32'(POOL_DEPTH);
  // The loaded count never passes the pool depth, so this also covers it.
  assign push_ok     = 32'(pool_index_i) < 32'(plc_q);
  assign stack_full  = (sp_q == SPW'(STACK_DEPTH));
  assign busy        = (state_q != fsbe_pkg::S_IDLE);

  always_ff @(posedge clk_i) begin
    if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
    stk_rdata_q <= stack_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pool_we) pool_mem[pool_addr] <= pool_value_i;
    pool_rdata_q <= pool_mem[pool_addr];
  end

  fsbe_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fpu_req),
    .a_i    (stk_rdata_q),
    .b_i    (rhs_q),
    .done_o (fpu_done),
    .res_o  (fpu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fsbe_pkg::S_IDLE;
      sp_q        <= '0;
      plc_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      plc_q       <= plc_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    rhs_q        <= rhs_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_level_q  <= res_level_d;
  end

  // Sequencer: checks the command against the stack and pool state, then
  // walks through the memory reads and the arithmetic unit it needs.
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    sp_d         = sp_q;
    plc_d        = plc_q;
    rhs_d        = rhs_q;
    stk_we       = 1'b0;
    stk_waddr    = top_addr;
    stk_wdata    = pool_rdata_q;
    stk_raddr    = top_addr;
    pool_we      = 1'b0;
    fpu_req      = '{start: 1'b0, op: op_q};
    res_valid_d  = 1'b0;
    res_status_d = fsbe_pkg::ST_DONE;
    res_value_d  = 64'd0;
    case (state_q)
      fsbe_pkg::S_IDLE: begin
        if (start) begin
          op_d = op_in;
          case (op_in)
            fsbe_pkg::OP_LOAD: begin
              res_valid_d = 1'b1;
              if (load_ok) begin
                pool_we = 1'b1;
                if (idx_plus1 > 32'(plc_q)) plc_d = PCW'(idx_plus1);
              end else begin
                res_status_d = fsbe_pkg::ST_BADINDEX;
              end
            end
            fsbe_pkg::OP_PUSH: begin
              if (!push_ok) begin
                res_valid_d  = 1'b1;
                res_status_d = fsbe_pkg::ST_BADINDEX;
              end else if (stack_full) begin
                res_valid_d  = 1'b1;
                res_status_d = fsbe_pkg::ST_OVERFLOW;
              end else begin
                state_d = fsbe_pkg::S_PUSH;
              end
            end
            fsbe_pkg::OP_NEG, fsbe_pkg::OP_RET: begin
              if (sp_q == '0) begin
                res_valid_d  = 1'b1;
                res_status_d = fsbe_pkg::ST_UNDERFLOW;
              end else begin
                state_d = (op_in == fsbe_pkg::OP_NEG) ? fsbe_pkg::S_NEG : fsbe_pkg::S_RET;
              end
            end
            default: begin
              // Binary operations need two values on the stack.
              if (sp_q < SPW'(2)) begin
                res_valid_d  = 1'b1;
                res_status_d = fsbe_pkg::ST_UNDERFLOW;
              end else begin
                state_d = fsbe_pkg::S_BIN_A;
              end
            end
          endcase
        end
      end
      fsbe_pkg::S_PUSH: begin
        stk_we      = 1'b1;
        stk_waddr   = SA'(sp_q);
        stk_wdata   = pool_rdata_q;
        sp_d        = sp_q + SPW'(1);
        res_valid_d = 1'b1;
        state_d     = fsbe_pkg::S_IDLE;
      end
      fsbe_pkg::S_NEG: begin
        stk_we      = 1'b1;
        stk_waddr   = top_addr;
        stk_wdata   = stk_rdata_q ^ fsbe_pkg::SignBit;
        res_valid_d = 1'b1;
        state_d     = fsbe_pkg::S_IDLE;
      end
      fsbe_pkg::S_RET: begin
        sp_d         = sp_q - SPW'(1);
        res_valid_d  = 1'b1;
        res_status_d = fsbe_pkg::ST_RETURNED;
        res_value_d  = stk_rdata_q;
        state_d      = fsbe_pkg::S_IDLE;
      end
      fsbe_pkg::S_BIN_A: begin
        // The top of the stack is the right operand.
        rhs_d     = stk_rdata_q;
        stk_raddr = second_addr;
        state_d   = fsbe_pkg::S_BIN_B;
      end
      fsbe_pkg::S_BIN_B: begin
        fpu_req = '{start: 1'b1, op: op_q};
        state_d = fsbe_pkg::S_BIN_WAIT;
      end
      fsbe_pkg::S_BIN_WAIT: begin
        if (fpu_done) begin
          stk_we      = 1'b1;
          stk_waddr   = second_addr;
          stk_wdata   = fpu_res;
          sp_d        = sp_q - SPW'(1);
          res_valid_d = 1'b1;
          state_d     = fsbe_pkg::S_IDLE;
        end
      end
      default: state_d = fsbe_pkg::S_IDLE;
    endcase
    res_level_d = 9'(sp_d);
  end

  assign valid_o        = res_valid_q;
  assign status_o       = res_status_q;
  assign return_value_o = res_value_q;
  assign stack_level_o  = res_level_q;

  // The stack count never passes the stack depth.
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack count beyond stack depth");

  // The arithmetic unit only reports back while the sequencer waits for it.
  a_fpu_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fpu_done |-> state_q == fsbe_pkg::S_BIN_WAIT)
    else $error("arithmetic result outside its wait state");

  // Only a return transfers a nonzero value.
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o != fsbe_pkg::ST_RETURNED)) |-> return_value_o == 64'd0)
    else $error("value on a result that is not a return");

  // A result of the sequencer is never produced while it starts the unit.
  a_no_result_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fpu_req.start |=> !valid_o)
    else $error("result during arithmetic start");

endmodule

// File: src/fsbe_fpu.sv
// Iterative double-precision unit for add, subtract, multiply and divide.
module fsbe_fpu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fsbe_pkg::fpu_req_t req_i,
  input  logic [63:0]        a_i,
  input  logic [63:0]        b_i,
  output logic               done_o,
  output logic [63:0]        res_o
);

  fsbe_pkg::fpu_state_e state_q, state_d;
  fsbe_pkg::op_e        op_q, op_d;
  logic [63:0]          a_q, a_d, b_q, b_d, res_q, res_d;
  logic                 done_q, done_d;
  logic                 s_q, s_d, sb_q, sb_d;
  logic [52:0]          ma_q, ma_d, mb_q, mb_d;
  logic signed [13:0]   ea_q, ea_d, eb_q, eb_d, e_q, e_d;
  logic [56:0]          m_q, m_d;
  logic [52:0]          u_q, u_d, l_q, l_d;
  logic [53:0]          rem_q, rem_d;
  logic [55:0]          quo_q, quo_d;
  logic [5:0]           cnt_q, cnt_d;

  function automatic logic [52:0] mant53(input logic [63:0] x);
    return {|x[62:52], x[51:0]};
  endfunction

  function automatic logic signed [13:0] exp_eff(input logic [63:0] x);
    return (x[62:52] == 11'd0) ? 14'sd1 : $signed({3'b000, x[62:52]});
  endfunction

  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, b_se, swap;
  assign a_nan  = (&a_q[62:52]) && (|a_q[51:0]);
  assign b_nan  = (&b_q[62:52]) && (|b_q[51:0]);
  assign a_inf  = (&a_q[62:52]) && !(|a_q[51:0]);
  assign b_inf  = (&b_q[62:52]) && !(|b_q[51:0]);
  assign a_zero = (a_q[62:0] == 63'd0);
  assign b_zero = (b_q[62:0] == 63'd0);
  assign b_se   = b_q[63] ^ (op_q == fsbe_pkg::OP_SUB);
  assign swap   = (a_q[62:0] < b_q[62:0]);

  // Alignment of the smaller addend with a sticky bit.
  logic signed [13:0] ediff;
  logic [5:0]         sh;
  logic [55:0]        small_m, shifted, al;
  logic               stk;
  logic [56:0]        asum;
  assign ediff   = ea_q - eb_q;
  assign sh      = (ediff > 14'sd56) ? 6'd56 : ediff[5:0];
  assign small_m = {mb_q, 3'b000};
  assign shifted = small_m >> sh;
  assign stk     = |(small_m & ~({56{1'b1}} << sh));
  assign al      = {shifted[55:1], shifted[0] | stk};
  assign asum    = (s_q == sb_q) ? ({1'b0, ma_q, 3'b000} + {1'b0, al})
                                 : ({1'b0, ma_q, 3'b000} - {1'b0, al});

  // One radix-2 step of the multiplier and the divider.
  logic [53:0]  psum;
  logic [105:0] prod;
  logic         ge;
  logic [53:0]  rdiff;
  assign psum  = {1'b0, u_q} + {1'b0, (mb_q[0] ? ma_q : 53'd0)};
  assign prod  = {u_q, l_q};
  assign ge    = (rem_q >= {1'b0, mb_q});
  assign rdiff = ge ? (rem_q - {1'b0, mb_q}) : rem_q;

  // Round to nearest even.
  logic               inc;
  logic [53:0]        rmant;
  logic signed [13:0] rexp;
  logic [51:0]        rfrac;
  assign inc   = m_q[2] & (m_q[1] | m_q[0] | m_q[3]);
  assign rmant = {1'b0, m_q[55:3]} + {53'd0, inc};
  assign rexp  = rmant[53] ? (e_q + 14'sd1) : (rmant[52] ? e_q : 14'sd0);
  assign rfrac = rmant[53] ? 52'd0 : rmant[51:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsbe_pkg::F_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    a_q   <= a_d;
    b_q   <= b_d;
    res_q <= res_d;
    s_q   <= s_d;
    sb_q  <= sb_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    ea_q  <= ea_d;
    eb_q  <= eb_d;
    e_q   <= e_d;
    m_q   <= m_d;
    u_q   <= u_d;
    l_q   <= l_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    op_d = op_q;  a_d = a_q;  b_d = b_q;  res_d = res_q;
    s_d = s_q;  sb_d = sb_q;  ma_d = ma_q;  mb_d = mb_q;
    ea_d = ea_q;  eb_d = eb_q;  e_d = e_q;  m_d = m_q;
    u_d = u_q;  l_d = l_q;  rem_d = rem_q;  quo_d = quo_q;  cnt_d = cnt_q;
    case (state_q)
      fsbe_pkg::F_IDLE: begin
        if (req_i.start) begin
          op_d    = req_i.op;
          a_d     = a_i;
          b_d     = b_i;
          state_d = fsbe_pkg::F_CHK;
        end
      end
      fsbe_pkg::F_CHK: begin
        if (a_nan) begin
          res_d = a_q | fsbe_pkg::QuietBit;  done_d = 1'b1;  state_d = fsbe_pkg::F_IDLE;
        end else if (b_nan) begin
          res_d = b_q | fsbe_pkg::QuietBit;  done_d = 1'b1;  state_d = fsbe_pkg::F_IDLE;
        end else begin
          case (op_q)
            fsbe_pkg::OP_ADD, fsbe_pkg::OP_SUB: begin
              if (a_inf && b_inf && (a_q[63] != b_se)) begin
                res_d = fsbe_pkg::DefaultNan;  done_d = 1'b1;  state_d = fsbe_pkg::F_IDLE;
              end else if (a_inf) begin
                res_d = a_q;  done_d = 1'b1;  state_d = fsbe_pkg::F_IDLE;
              end else if (b_inf) begin
                res_d = {b_se, b_q[62:0]};  done_d = 1'b1;  state_d = fsbe_pkg::F_IDLE;
              end else begin
                if (swap) begin
                  s_d = b_se;  sb_d = a_q[63];
                  ma_d = mant53(b_q);  ea_d = exp_eff(b_q);
                  mb_d = mant53(a_q);  eb_d = exp_eff(a_q);
                end else begin
                  s_d = a_q[63];  sb_d = b_se;
                  ma_d = mant53(a_q);  ea_d = exp_eff(a_q);
                  mb_d = mant53(b_q);  eb_d = exp_eff(b_q);
                end
                state_d = fsbe_pkg::F_ADD;
              end
            end
            fsbe_pkg::OP_MUL, fsbe_pkg::OP_DIV: begin
              s_d  = a_q[63] ^ b_q[63];
              ma_d = mant53(a_q);  ea_d = exp_eff(a_q);
              mb_d = mant53(b_q);  eb_d = exp_eff(b_q);
              state_d = fsbe_pkg::F_PRE;
              if (op_q == fsbe_pkg::OP_MUL) begin
                if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                  res_d = fsbe_pkg::DefaultNan;  done_d = 1'b1;  state_d = fsbe_pkg::F_IDLE;
                end else if (a_inf || b_inf) begin
                  res_d = {a_q[63] ^ b_q[63], 11'h7FF, 52'd0};
                  done_d = 1'b1;  state_d = fsbe_pkg::F_IDLE;
                end else if (a_zero || b_zero) begin
                  res_d = {a_q[63] ^ b_q[63], 63'd0};
                  done_d = 1'b1;  state_d = fsbe_pkg::F_IDLE;
                end
              end else begin
                if ((a_inf && b_inf) || (a_zero && b_zero)) begin
                  res_d = fsbe_pkg::DefaultNan;  done_d = 1'b1;  state_d = fsbe_pkg::F_IDLE;
                end else if (a_inf || b_zero) begin
                  res_d = {a_q[63] ^ b_q[63], 11'h7FF, 52'd0};
                  done_d = 1'b1;  state_d = fsbe_pkg::F_IDLE;
                end else if (a_zero || b_inf) begin
                  res_d = {a_q[63] ^ b_q[63], 63'd0};
                  done_d = 1'b1;  state_d = fsbe_pkg::F_IDLE;
                end
              end
            end
            default: begin
              res_d = fsbe_pkg::DefaultNan;  done_d = 1'b1;  state_d = fsbe_pkg::F_IDLE;
            end
          endcase
        end
      end
      fsbe_pkg::F_ADD: begin
        m_d = asum;
        e_d = ea_q;
        // An exact cancellation gives positive zero.
        if ((asum == 57'd0) && (s_q != sb_q)) s_d = 1'b0;
        state_d = fsbe_pkg::F_NORM;
      end
      fsbe_pkg::F_PRE: begin
        // Subnormal operands get a leading one before the multiply or divide.
        if (!ma_q[52]) begin
          ma_d = {ma_q[51:0], 1'b0};
          ea_d = ea_q - 14'sd1;
        end
        if (!mb_q[52]) begin
          mb_d = {mb_q[51:0], 1'b0};
          eb_d = eb_q - 14'sd1;
        end
        if (ma_q[52] && mb_q[52]) begin
          cnt_d = 6'd0;
          u_d   = 53'd0;
          l_d   = 53'd0;
          rem_d = {1'b0, ma_q};
          quo_d = 56'd0;
          state_d = (op_q == fsbe_pkg::OP_MUL) ? fsbe_pkg::F_MUL : fsbe_pkg::F_DIV;
        end
      end
      fsbe_pkg::F_MUL: begin
        if (cnt_q == 6'd53) begin
          m_d = {prod[105:50], |prod[49:0]};
          e_d = ea_q + eb_q - fsbe_pkg::ExpBias;
          state_d = fsbe_pkg::F_NORM;
        end else begin
          u_d   = psum[53:1];
          l_d   = {psum[0], l_q[52:1]};
          mb_d  = {1'b0, mb_q[52:1]};
          cnt_d = cnt_q + 6'd1;
        end
      end
      fsbe_pkg::F_DIV: begin
        if (cnt_q == 6'd56) begin
          m_d = {1'b0, quo_q[55:1], quo_q[0] | (|rem_q)};
          e_d = ea_q - eb_q + fsbe_pkg::ExpBias;
          state_d = fsbe_pkg::F_NORM;
        end else begin
          quo_d = {quo_q[54:0], ge};
          rem_d = {rdiff[52:0], 1'b0};
          cnt_d = cnt_q + 6'd1;
        end
      end
      fsbe_pkg::F_NORM: begin
        if (m_q[56] || (e_q < 14'sd1)) begin
          if (e_q < -14'sd60) begin
            m_d = {56'd0, |m_q};
            e_d = 14'sd1;
          end else begin
            m_d = {1'b0, m_q[56:2], m_q[1] | m_q[0]};
            e_d = e_q + 14'sd1;
          end
        end else if (!m_q[55] && (e_q > 14'sd1) && (m_q != 57'd0)) begin
          m_d = {m_q[55:0], 1'b0};
          e_d = e_q - 14'sd1;
        end else begin
          state_d = fsbe_pkg::F_ROUND;
        end
      end
      fsbe_pkg::F_ROUND: begin
        if (rexp >= 14'sd2047) res_d = {s_q, 11'h7FF, 52'd0};
        else                   res_d = {s_q, rexp[10:0], rfrac};
        done_d  = 1'b1;
        state_d = fsbe_pkg::F_IDLE;
      end
      default: state_d = fsbe_pkg::F_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
